// ===== rtl/mandelbrot_escape_time_pixel_macros.svh =====
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MBE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbe_pkg.sv =====
`default_nettype none

package mbe_pkg;

  localparam int unsigned FracBits = 28;
  localparam int unsigned CountW   = 9;
  localparam logic [CountW-1:0] NotEscaped = 9'd256;

  typedef enum logic [2:0] {
    CfgOriginReal   = 3'd0,
    CfgOriginImag   = 3'd1,
    CfgStepReal     = 3'd2,
    CfgStepImag     = 3'd3,
    CfgEscapeRadius = 3'd4,
    CfgMaxIter      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
  } point_t;

  typedef struct packed {
    logic [3:0]        radius_sq;
    logic [CountW-1:0] limit;
  } iter_cfg_t;

  // clamp to the signed Q4.28 range
  function automatic logic signed [31:0] sat_q428(input logic signed [43:0] v);
    logic signed [31:0] r;
    if (v > 44'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -44'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbe_coord.sv =====
`default_nettype none

module mbe_coord import mbe_pkg::*; #(
  parameter int unsigned IMAGE_WIDTH  = 4096,
  parameter int unsigned IMAGE_HEIGHT = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] origin_real_i,
  input  logic signed [31:0] origin_imag_i,
  input  logic [28:0]        step_real_i,
  input  logic [28:0]        step_imag_i,
  input  logic               pixel_valid_i,
  output logic               pixel_ready_o,
  input  logic [11:0]        pixel_x_i,
  input  logic [11:0]        pixel_y_i,
  output logic               point_valid_o,
  input  logic               point_ready_i,
  output point_t             point_o
);

  localparam logic [31:0] LastCol = 32'(IMAGE_WIDTH - 1);
  localparam logic [31:0] LastRow = 32'(IMAGE_HEIGHT - 1);

  logic [11:0]        px, py;
  logic               a_v_q, b_v_q;
  logic               a_ready, b_ready;
  logic [40:0]        prod_re_q, prod_im_q;
  logic signed [43:0] sum_re, sum_im;
  point_t             point_q;

  // indices past the image edge stick to the last column or row
  assign px = (32'(pixel_x_i) >= 32'(IMAGE_WIDTH))  ? LastCol[11:0] : pixel_x_i;
  assign py = (32'(pixel_y_i) >= 32'(IMAGE_HEIGHT)) ? LastRow[11:0] : pixel_y_i;

  assign b_ready       = !b_v_q || point_ready_i;
  assign a_ready       = !a_v_q || b_ready;
  assign pixel_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_ready) a_v_q <= pixel_valid_i;
      if (b_ready) b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && pixel_valid_i) begin
      prod_re_q <= 41'(px) * 41'(step_real_i);
      prod_im_q <= 41'(py) * 41'(step_imag_i);
    end
  end

  assign sum_re = 44'(origin_real_i) + $signed({3'b000, prod_re_q});
  assign sum_im = 44'(origin_imag_i) + $signed({3'b000, prod_im_q});

  always_ff @(posedge clk_i) begin
    if (b_ready && a_v_q) begin
      point_q.c_re <= sat_q428(sum_re);
      point_q.c_im <= sat_q428(sum_im);
    end
  end

  assign point_valid_o = b_v_q;
  assign point_o       = point_q;

endmodule

`default_nettype wire

// ===== rtl/mbe_iter.sv =====
`default_nettype none

module mbe_iter import mbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iter_cfg_t         cfg_i,
  input  logic              point_valid_i,
  output logic              point_ready_o,
  input  point_t            point_i,
  input  logic              out_free_i,
  output logic              done_valid_o,
  output logic [CountW-1:0] done_count_o
);

  typedef struct packed {
    logic               done;
    logic [1:0]         tag;
    logic [CountW-1:0]  count;
    logic signed [31:0] z_re;
    logic signed [31:0] z_im;
    point_t             c;
  } slot_t;

  typedef struct packed {
    slot_t              s;
    logic signed [63:0] rr;
    logic signed [63:0] ii;
    logic signed [63:0] ri;
  } s1_t;

  typedef struct packed {
    slot_t              s;
    logic               esc;
    logic signed [63:0] diff;
    logic signed [63:0] ri;
  } s2_t;

  logic        v1_q, v2_q, v3_q;
  s1_t         p1_q, p1_d;
  s2_t         p2_q, p2_d;
  slot_t       p3_q, p3_d;
  slot_t       s0;
  logic        v0;
  logic [1:0]  issue_q, retire_q;
  logic        exit_now, ring_free, take;
  logic [63:0] mag, bound;
  logic signed [31:0] n_re, n_im;

  // three slots circulate; a finished pixel leaves only when it is the oldest
  assign exit_now  = v3_q && p3_q.done && (p3_q.tag == retire_q) && out_free_i;
  assign ring_free = !v3_q || exit_now;
  assign take      = ring_free && point_valid_i;
  assign point_ready_o = ring_free;

  always_comb begin
    if (ring_free) begin
      v0       = point_valid_i;
      s0.done  = 1'b0;
      s0.tag   = issue_q;
      s0.count = CountW'(1);
      s0.z_re  = '0;
      s0.z_im  = '0;
      s0.c     = point_i;
    end else begin
      v0 = 1'b1;
      s0 = p3_q;
    end
  end

  // stage 1: the three products of z
  always_comb begin
    p1_d.s  = s0;
    p1_d.rr = 64'(s0.z_re) * 64'(s0.z_re);
    p1_d.ii = 64'(s0.z_im) * 64'(s0.z_im);
    p1_d.ri = 64'(s0.z_re) * 64'(s0.z_im);
  end

  // stage 2: escape test on the current z, real difference
  assign mag   = $unsigned(p1_q.rr) + $unsigned(p1_q.ii);
  assign bound = {4'b0000, cfg_i.radius_sq, 56'd0};

  always_comb begin
    p2_d.s    = p1_q.s;
    p2_d.esc  = !(mag < bound);
    p2_d.diff = p1_q.rr - p1_q.ii;
    p2_d.ri   = p1_q.ri;
  end

  // stage 3: new z, count update, stop decision
  assign n_re = sat_q428(44'(p2_q.diff >>> FracBits) + 44'($signed(p2_q.s.c.c_re)));
  assign n_im = sat_q428(44'(p2_q.ri >>> (FracBits - 1)) + 44'($signed(p2_q.s.c.c_im)));

  always_comb begin
    p3_d = p2_q.s;
    if (!p2_q.s.done) begin
      if (p2_q.esc) begin
        p3_d.done = 1'b1;
      end else if (p2_q.s.count >= cfg_i.limit) begin
        p3_d.done  = 1'b1;
        p3_d.count = NotEscaped;
      end else begin
        p3_d.z_re  = n_re;
        p3_d.z_im  = n_im;
        p3_d.count = p2_q.s.count + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      issue_q  <= '0;
      retire_q <= '0;
    end else begin
      v1_q <= v0;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (take)     issue_q  <= issue_q + 2'd1;
      if (exit_now) retire_q <= retire_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    p2_q <= p2_d;
    p3_q <= p3_d;
  end

  assign done_valid_o = exit_now;
  assign done_count_o = p3_q.count;

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// Mandelbrot escape-time unit: one pixel beat in, one iteration count out.
// Pixel channel (pixel_valid_i/pixel_ready_o) takes a column and row index;
// indices past the image edge are clamped to the last column or row.
// Result channel (iter_valid_o/iter_ready_i) returns 1 up to max_iter capped
// at ITER_LIMIT_MAX, or 256 if not escaped. Results come back in input order.
// Config channel (cfg_valid_i/cfg_ready_o) is always ready; write it only
// while no pixel is in flight.
// Path: two registers (products, then the saturated sum) map the pixel
// to c, then each pass runs through the three-stage iteration loop
// (multiply, escape test, update); an output register holds the result.
// A new pixel enters the loop only when a slot is free.
// Sharing: three pixels share the loop, one per stage, so a new pixel
// can enter before the one ahead is done; a long pixel ahead holds back
// the ones behind it at the output, since they retire in order.
// Reset loads the default view (-2-2i, step 265318, radius 2, limit 256)
// and empties the pipeline. When the receiver stalls, finished pixels keep
// circulating in the loop and new pixels wait at the input; nothing is lost.
`default_nettype none

module mandelbrot_escape_time_pixel import mbe_pkg::*; #(
  parameter int unsigned IMAGE_WIDTH    = 4096,
  parameter int unsigned IMAGE_HEIGHT   = 4096,
  parameter int unsigned ITER_LIMIT_MAX = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              pixel_valid_i,
  output logic              pixel_ready_o,
  input  logic [11:0]       pixel_x_i,
  input  logic [11:0]       pixel_y_i,
  output logic              iter_valid_o,
  input  logic              iter_ready_i,
  output logic [CountW-1:0] iter_count_o
);

  logic signed [31:0] origin_real_q, origin_imag_q;
  logic [28:0]        step_real_q, step_imag_q;
  logic [1:0]         escape_radius_q;
  logic [CountW-1:0]  max_iter_q;
  iter_cfg_t          iter_cfg;
  logic               point_valid, point_ready;
  point_t             point;
  logic               out_free, done_valid;
  logic [CountW-1:0]  done_count;
  logic               iter_valid_q;
  logic [CountW-1:0]  iter_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_real_q   <= 32'shE000_0000;
      origin_imag_q   <= 32'shE000_0000;
      step_real_q     <= 29'd265318;
      step_imag_q     <= 29'd265318;
      escape_radius_q <= 2'd2;
      max_iter_q      <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgOriginReal:   origin_real_q   <= $signed(cfg_data_i);
        CfgOriginImag:   origin_imag_q   <= $signed(cfg_data_i);
        CfgStepReal:     step_real_q     <= cfg_data_i[28:0];
        CfgStepImag:     step_imag_q     <= cfg_data_i[28:0];
        CfgEscapeRadius: escape_radius_q <= cfg_data_i[1:0];
        CfgMaxIter:      max_iter_q      <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign iter_cfg.radius_sq = 4'(escape_radius_q) * 4'(escape_radius_q);
  assign iter_cfg.limit = (32'(max_iter_q) > 32'(ITER_LIMIT_MAX)) ?
                          CountW'(ITER_LIMIT_MAX) : max_iter_q;

  mbe_coord #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_coord (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .origin_real_i (origin_real_q),
    .origin_imag_i (origin_imag_q),
    .step_real_i   (step_real_q),
    .step_imag_i   (step_imag_q),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .point_valid_o (point_valid),
    .point_ready_i (point_ready),
    .point_o       (point)
  );

  mbe_iter u_iter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (iter_cfg),
    .point_valid_i (point_valid),
    .point_ready_o (point_ready),
    .point_i       (point),
    .out_free_i    (out_free),
    .done_valid_o  (done_valid),
    .done_count_o  (done_count)
  );

  // output register
  assign out_free = !iter_valid_q || iter_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_valid_q <= 1'b0;
    end else if (out_free) begin
      iter_valid_q <= done_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && done_valid) iter_count_q <= done_count;
  end

  assign iter_valid_o = iter_valid_q;
  assign iter_count_o = iter_count_q;

endmodule

`default_nettype wire

// ===== rtl/mbe_checker.sv =====
`default_nettype none
`include "mandelbrot_escape_time_pixel_macros.svh"

module mbe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pixel_valid_i,
  input logic       pixel_ready_o,
  input logic       iter_valid_o,
  input logic       iter_ready_i,
  input logic [8:0] iter_count_o
);

  logic [3:0] outstanding_q;
  logic       in_beat, out_beat;

  assign in_beat  = pixel_valid_i && pixel_ready_o;
  assign out_beat = iter_valid_o && iter_ready_i;

  // pixels taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + 4'(in_beat) - 4'(out_beat);
    end
  end

  `MBE_ASSERT_IMPL(a_count_nonzero, iter_valid_o, iter_count_o != 9'd0, "zero iteration count")
  `MBE_ASSERT_IMPL(a_no_phantom, iter_valid_o, outstanding_q != 4'd0, "result without a pixel")
  `MBE_ASSERT_IMPL(a_capacity, 1'b1, outstanding_q <= 4'd6, "more pixels in flight than slots")
  `MBE_ASSERT_NEXT(a_hold, iter_valid_o && !iter_ready_i, iter_valid_o && $stable(iter_count_o), "stalled result changed")

endmodule

bind mandelbrot_escape_time_pixel mbe_checker u_mbe_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import mbe_pkg::*;

  localparam int ImageWidth   = 4096;
  localparam int ImageHeight  = 4096;
  localparam int IterLimitMax = 256;
  localparam int PixelTarget  = 1650;
  localparam int TailCycles   = 800;
  localparam longint CycleLimit = 6_000_000;

  // indexes with no register behind them
  localparam logic [2:0] CfgNone6 = 3'd6;
  localparam logic [2:0] CfgNone7 = 3'd7;

  class escape_board;
    logic signed [31:0] org_re;
    logic signed [31:0] org_im;
    logic [28:0]        stp_re;
    logic [28:0]        stp_im;
    logic [1:0]         radius;
    logic [8:0]         iter_lim;
    logic [8:0]         pending_counts[$];
    int                 errors;

    function new();
      org_re   = -32'sd536870912;
      org_im   = -32'sd536870912;
      stp_re   = 29'd265318;
      stp_im   = 29'd265318;
      radius   = 2'd2;
      iter_lim = 9'd256;
      errors   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CfgOriginReal:   org_re   = data;
        CfgOriginImag:   org_im   = data;
        CfgStepReal:     stp_re   = data[28:0];
        CfgStepImag:     stp_im   = data[28:0];
        CfgEscapeRadius: radius   = data[1:0];
        CfgMaxIter:      iter_lim = data[8:0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp_q428(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function longint unsigned mag_of(longint re, longint im);
      longint unsigned r2;
      longint unsigned i2;
      r2 = re * re;
      i2 = im * im;
      return r2 + i2;
    endfunction

    function logic signed [31:0] map_axis(logic signed [31:0] org, logic [28:0] stp,
                                          logic [11:0] idx, int size);
      longint pos;
      longint inc;
      longint sum;
      pos = idx;
      if (pos >= size) pos = size - 1;
      inc = stp;
      sum = org;
      sum = sum + pos * inc;
      return clamp_q428(sum);
    endfunction

    function logic [8:0] escape_count(logic [11:0] px, logic [11:0] py);
      longint c_re;
      longint c_im;
      longint re;
      longint im;
      longint n_re;
      longint n_im;
      longint unsigned rad;
      longint unsigned esc_bound;
      int cnt;
      int lim;
      c_re = map_axis(org_re, stp_re, px, ImageWidth);
      c_im = map_axis(org_im, stp_im, py, ImageHeight);
      rad = radius;
      esc_bound = (rad * rad) << 56;
      lim = (iter_lim > IterLimitMax) ? IterLimitMax : int'(iter_lim);
      re = 0;
      im = 0;
      cnt = 1;
      while (mag_of(re, im) < esc_bound && cnt < lim) begin
        // arithmetic shift floors toward minus infinity
        n_re = clamp_q428(((re * re - im * im) >>> 28) + c_re);
        n_im = clamp_q428(((re * im) >>> 27) + c_im);
        re = n_re;
        im = n_im;
        cnt++;
      end
      if (mag_of(re, im) < esc_bound && cnt >= lim) return NotEscaped;
      return cnt[8:0];
    endfunction

    function void note_pixel(logic [11:0] px, logic [11:0] py);
      pending_counts.push_back(escape_count(px, py));
    endfunction

    function void check_count(logic [8:0] got);
      logic [8:0] want;
      if (pending_counts.size() == 0) begin
        $error("iter_count: unexpected beat, expected none, actual %0d", got);
        errors++;
      end else begin
        want = pending_counts.pop_front();
        if (want !== got) begin
          $error("iter_count: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CfgOriginReal;
  logic [31:0] cfg_data_i = '0;
  logic        pixel_valid_i = 1'b0;
  logic        pixel_ready_o;
  logic [11:0] pixel_x_i = '0;
  logic [11:0] pixel_y_i = '0;
  logic        iter_valid_o;
  logic        iter_ready_i = 1'b0;
  logic [CountW-1:0] iter_count_o;

  escape_board board;
  longint      cycles = 0;
  int          stall_left = 0;
  int          window = 0;
  bit          calm = 1'b1;

  mandelbrot_escape_time_pixel #(
    .IMAGE_WIDTH(ImageWidth),
    .IMAGE_HEIGHT(ImageHeight),
    .ITER_LIMIT_MAX(IterLimitMax)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .pixel_valid_i(pixel_valid_i),
    .pixel_ready_o(pixel_ready_o),
    .pixel_x_i(pixel_x_i),
    .pixel_y_i(pixel_y_i),
    .iter_valid_o(iter_valid_o),
    .iter_ready_i(iter_ready_i),
    .iter_count_o(iter_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: calm windows with ready held high, otherwise random stall runs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_ready_i <= 1'b0;
    end else begin
      if (iter_valid_o && iter_ready_i) board.check_count(iter_count_o);
      window++;
      if (window == 400) begin
        window = 0;
        calm = ($urandom_range(0, 2) == 0);
      end
      if (calm) begin
        iter_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        iter_ready_i <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        iter_ready_i <= 1'b0;
      end else begin
        iter_ready_i <= 1'b1;
      end
    end
  end

  // leaves cfg_valid_i high; the caller lowers it after the last write
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  task automatic apply_view(logic [31:0] ore, logic [31:0] oim, logic [31:0] sre,
                            logic [31:0] sim, logic [31:0] rad, logic [31:0] lim);
    write_reg(CfgOriginReal, ore);
    write_reg(CfgOriginImag, oim);
    write_reg(CfgStepReal, sre);
    write_reg(CfgStepImag, sim);
    write_reg(CfgEscapeRadius, rad);
    write_reg(CfgMaxIter, lim);
    cfg_valid_i <= 1'b0;
  endtask

  // leaves pixel_valid_i high so a burst runs back to back
  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    pixel_valid_i <= 1'b1;
    pixel_x_i     <= px;
    pixel_y_i     <= py;
    @(posedge clk_i);
    while (!pixel_ready_o) @(posedge clk_i);
    board.note_pixel(px, py);
  endtask

  task automatic end_burst();
    pixel_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (board.pending_counts.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [11:0] pick_index();
    case ($urandom_range(0, 7))
      0:       return 12'd0;
      1:       return 12'd4095;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic random_view();
    logic [31:0] ore;
    logic [31:0] oim;
    logic [31:0] sre;
    logic [31:0] sim;
    logic [31:0] rad;
    logic [31:0] lim;
    if ($urandom_range(0, 9) < 7) begin
      // a window somewhere around the set, coarse or zoomed in
      ore = -671088640 + $urandom_range(0, 805306368);
      oim = -402653184 + $urandom_range(0, 805306368);
      sre = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 196608);
      sim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 196608);
      case ($urandom_range(0, 9))
        0:       rad = 0;
        1:       rad = 1;
        2:       rad = 3;
        default: rad = 2;
      endcase
      case ($urandom_range(0, 11))
        0:       lim = $urandom_range(0, 1);
        1:       lim = 256;
        2:       lim = $urandom_range(257, 511);
        default: lim = $urandom_range(2, 48);
      endcase
    end else begin
      ore = $urandom;
      oim = $urandom;
      sre = ($urandom_range(0, 4) == 0) ? 32'd268435456 : $urandom;
      sim = ($urandom_range(0, 4) == 0) ? 32'd268435456 : $urandom;
      rad = $urandom;
      lim = $urandom;
    end
    if ($urandom_range(0, 5) == 0) write_reg(($urandom_range(0, 1) != 0) ? CfgNone6 : CfgNone7,
                                             $urandom);
    apply_view(ore, oim, sre, sim, rad, lim);
  endtask

  task automatic run_pixels(int n);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        send_pixel(pick_index(), pick_index());
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) pixel_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (pixel_valid_i) end_burst();
  endtask

  initial begin
    int total;
    int n;
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default view after reset: corners and the middle of the image
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    end_burst();

    // zero radius answers one at once
    drain();
    apply_view(-536870912, -536870912, 265318, 265318, 0, 256);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd100, 12'd3000);
    end_burst();

    // limit of zero and of one: no iteration at all
    drain();
    apply_view(-536870912, -536870912, 265318, 265318, 3, 0);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd0);
    end_burst();
    drain();
    apply_view(-536870912, -536870912, 265318, 265318, 2, 1);
    send_pixel(12'd2048, 12'd2048);
    end_burst();

    // c saturates on both axes, limit above the maximum
    drain();
    apply_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1FFF_FFFF, 32'h1FFF_FFFF, 3, 511);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd0);
    end_burst();

    // second iterate leaves the q4.28 range in both directions
    drain();
    apply_view(-134217728, -805306368, 26843546, 26843546, 3, 300);
    send_pixel(12'd0, 12'd59);
    send_pixel(12'd30, 12'd45);
    send_pixel(12'd34, 12'd30);
    end_burst();

    // short limit, stray writes to unused indexes in between
    drain();
    write_reg(CfgNone6, 32'hFFFF_FFFF);
    write_reg(CfgNone7, 32'h0000_0000);
    apply_view(-536870912, -536870912, 265318, 265318, 2, 20);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd1000, 12'd1500);
    send_pixel(12'd3000, 12'd2500);
    end_burst();

    total = 0;
    while (total < PixelTarget) begin
      drain();
      random_view();
      n = $urandom_range(40, 120);
      run_pixels(n);
      total += n;
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending_counts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mbe_pkg.sv
rtl/mbe_coord.sv
rtl/mbe_iter.sv
rtl/mandelbrot_escape_time_pixel.sv
rtl/mbe_checker.sv
bench/tb.sv
